### rtl/de2u_pkg.sv
`timescale 1ns / 1ps

package de2u_pkg;

    typedef logic [63:0] dbl_t;

    localparam logic [1:0] SPEC_NONE = 2'd0;
    localparam logic [1:0] SPEC_NAN  = 2'd1;
    localparam logic [1:0] SPEC_INF  = 2'd2;
    localparam logic [1:0] SPEC_ZERO = 2'd3;

    typedef struct packed {
        logic [63:0]        x_raw;
        logic [63:0]        f;
        logic signed [11:0] k;
        logic [1:0]         spec;
        logic               f_neg;
    } tag_t;

    localparam dbl_t ONE      = 64'h3FF0000000000000;
    localparam dbl_t MIN_NORM = 64'h0010000000000000;
    localparam dbl_t POS_INF  = 64'h7FF0000000000000;
    localparam dbl_t QNAN     = 64'h7FF8000000000000;

    localparam logic [10:0] EXP_ONE    = 11'd1023;
    localparam logic [10:0] EXP_BIG    = 11'd1033;
    localparam logic [51:0] FRAC_SMALL = {10'd51, 42'd0};

    localparam logic signed [11:0] K_BIAS     = 12'sd1023;
    localparam logic signed [11:0] K_MIN_NORM = 12'sd1022;

    localparam int NCOEF = 7;

    localparam dbl_t COEF [0:NCOEF-1] = '{
        $realtobits(0.693147180559945286),
        $realtobits(0.240226506959100712),
        $realtobits(0.055504108664821609),
        $realtobits(0.009618129107628477),
        $realtobits(0.001333355814642844),
        $realtobits(0.000154035303933816),
        $realtobits(0.000015252733804456)
    };

endpackage

### rtl/de2u_in_if.sv
`timescale 1ns / 1ps

interface de2u_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] x_bits;

    modport source (output valid, output x_bits, input ready);
    modport sink (input valid, input x_bits, output ready);
endinterface

### rtl/de2u_out_if.sv
`timescale 1ns / 1ps

interface de2u_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink (input valid, input result_bits, output ready);
endinterface

### rtl/de2u_rred.sv
`timescale 1ns / 1ps

module de2u_rred (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  de2u_pkg::dbl_t  x,
    output logic            out_vld,
    output de2u_pkg::dbl_t  a,
    output de2u_pkg::dbl_t  b,
    output de2u_pkg::tag_t  tag_out
);

    logic [10:0]        e;
    logic [10:0]        s;
    logic [51:0]        mask;
    logic [10:0]        mag;
    logic signed [11:0] k;
    logic [63:0]        t;
    logic [1:0]         spec;
    logic               vld_reg;
    de2u_pkg::dbl_t     a_reg;
    de2u_pkg::dbl_t     b_reg;
    de2u_pkg::tag_t     tag_reg;
    de2u_pkg::tag_t     tag_next;

    always_comb
    begin
        e    = x[62:52];
        s    = e - de2u_pkg::EXP_ONE;
        mask = (s >= 11'd52) ? {52{1'b1}} : ~({52{1'b1}} >> s[5:0]);
        mag  = {1'b1, x[51:42]} >> (4'd10 - s[3:0]);
        if (e < de2u_pkg::EXP_ONE)
        begin
            t = 64'd0;
            k = 12'sd0;
        end
        else
        begin
            t = {x[63], x[62:52], x[51:0] & mask};
            k = x[63] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
        if (e == 11'h7FF && x[51:0] != 52'd0)
            spec = de2u_pkg::SPEC_NAN;
        else if (!x[63] && e >= de2u_pkg::EXP_BIG)
            spec = de2u_pkg::SPEC_INF;
        else if (x[63] && (e > de2u_pkg::EXP_BIG ||
                 (e == de2u_pkg::EXP_BIG && x[51:0] >= de2u_pkg::FRAC_SMALL)))
            spec = de2u_pkg::SPEC_ZERO;
        else
            spec = de2u_pkg::SPEC_NONE;
        tag_next       = '0;
        tag_next.x_raw = x;
        tag_next.k     = k;
        tag_next.spec  = spec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= x;
            b_reg   <= {~t[63], t[62:0]};
            tag_reg <= tag_next;
        end
    end

    assign out_vld = vld_reg;
    assign a       = a_reg;
    assign b       = b_reg;
    assign tag_out = tag_reg;

endmodule

### rtl/de2u_fmul.sv
`timescale 1ns / 1ps

module de2u_fmul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  de2u_pkg::dbl_t  a,
    input  de2u_pkg::dbl_t  b,
    input  de2u_pkg::tag_t  tag_in,
    output logic            out_vld,
    output de2u_pkg::dbl_t  res,
    output de2u_pkg::tag_t  tag_out
);

    typedef struct packed {
        logic sign;
        logic zero;
        logic inf;
        logic nan;
    } mfl_t;

    logic [52:0]         ma;
    logic [52:0]         mb;
    logic [11:0]         ea;
    logic [11:0]         eb;
    mfl_t                fl_next;
    logic [105:0]        p_next;
    logic [6:0]          lz_next;
    logic signed [14:0]  lim;
    logic signed [14:0]  lzs;
    logic signed [14:0]  sh;
    logic signed [14:0]  rs;
    logic [6:0]          amt;
    logic [105:0]        n_next;
    logic                st_next;
    logic signed [14:0]  ef_next;
    logic [10:0]         ef_fld;
    logic                rnd;
    logic [62:0]         rounded;
    de2u_pkg::dbl_t      res_next;

    logic [4:0]          vld_reg;
    de2u_pkg::tag_t      tag_reg [0:4];
    mfl_t                fl_reg [0:3];
    logic [51:0]         hh_reg;
    logic [52:0]         hl_reg;
    logic [52:0]         lh_reg;
    logic [53:0]         ll_reg;
    logic [11:0]         esum_reg [0:2];
    logic [105:0]        p_reg [0:1];
    logic [6:0]          lz_reg;
    logic [105:0]        n_reg;
    logic                st_reg;
    logic signed [14:0]  ef_reg;
    de2u_pkg::dbl_t      res_reg;

    // unpack
    always_comb
    begin
        ma = {a[62:52] != 11'd0, a[51:0]};
        mb = {b[62:52] != 11'd0, b[51:0]};
        ea = (a[62:52] == 11'd0) ? 12'd1 : {1'b0, a[62:52]};
        eb = (b[62:52] == 11'd0) ? 12'd1 : {1'b0, b[62:52]};
        fl_next.sign = a[63] ^ b[63];
        fl_next.zero = (ma == 53'd0) || (mb == 53'd0);
        fl_next.inf  = (a[62:52] == 11'h7FF) || (b[62:52] == 11'h7FF);
        fl_next.nan  = (a[62:52] == 11'h7FF && a[51:0] != 52'd0) ||
                       (b[62:52] == 11'h7FF && b[51:0] != 52'd0) ||
                       (fl_next.inf && fl_next.zero);
    end

    // sum partial products
    assign p_next = {hh_reg, 54'd0} + ((106'(hl_reg) + 106'(lh_reg)) << 27) + 106'(ll_reg);

    // leading zeros
    always_comb
    begin
        lz_next = 7'd106;
        for (int i = 0; i < 106; i++)
        begin
            if (p_reg[0][i])
                lz_next = 7'(105 - i);
        end
    end

    // normalize, limited by the subnormal boundary
    always_comb
    begin
        lim = $signed({3'b000, esum_reg[2]}) - 15'sd1023;
        lzs = $signed({8'd0, lz_reg});
        sh  = (lim < lzs) ? lim : lzs;
        ef_next = lim + 15'sd1 - sh;
        rs  = -sh;
        amt = (rs > 15'sd127) ? 7'd127 : rs[6:0];
        if (sh >= 15'sd0)
        begin
            n_next  = p_reg[1] << sh[6:0];
            st_next = 1'b0;
        end
        else
        begin
            n_next  = p_reg[1] >> amt;
            st_next = |(p_reg[1] & ~({106{1'b1}} << amt));
        end
    end

    // round to nearest even
    always_comb
    begin
        ef_fld  = n_reg[105] ? ef_reg[10:0] : 11'd0;
        rnd     = n_reg[52] & ((|n_reg[51:0]) | st_reg | n_reg[53]);
        rounded = {ef_fld, n_reg[104:53]} + 63'(rnd);
        if (fl_reg[3].nan)
            res_next = de2u_pkg::QNAN;
        else if (fl_reg[3].inf)
            res_next = {fl_reg[3].sign, de2u_pkg::POS_INF[62:0]};
        else if (fl_reg[3].zero)
            res_next = {fl_reg[3].sign, 63'd0};
        else if (n_reg[105] && ef_reg >= 15'sd2047)
            res_next = {fl_reg[3].sign, de2u_pkg::POS_INF[62:0]};
        else
            res_next = {fl_reg[3].sign, rounded};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg      <= ma[52:27] * mb[52:27];
            hl_reg      <= ma[52:27] * mb[26:0];
            lh_reg      <= ma[26:0] * mb[52:27];
            ll_reg      <= ma[26:0] * mb[26:0];
            esum_reg[0] <= ea + eb;
            esum_reg[1] <= esum_reg[0];
            esum_reg[2] <= esum_reg[1];
            p_reg[0]    <= p_next;
            p_reg[1]    <= p_reg[0];
            lz_reg      <= lz_next;
            n_reg       <= n_next;
            st_reg      <= st_next;
            ef_reg      <= ef_next;
            res_reg     <= res_next;
            fl_reg[0]   <= fl_next;
            tag_reg[0]  <= tag_in;
            for (int i = 1; i < 4; i++)
                fl_reg[i] <= fl_reg[i-1];
            for (int i = 1; i < 5; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    assign out_vld = vld_reg[4];
    assign res     = res_reg;
    assign tag_out = tag_reg[4];

endmodule

### rtl/de2u_fadd.sv
`timescale 1ns / 1ps

module de2u_fadd (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  de2u_pkg::dbl_t  a,
    input  de2u_pkg::dbl_t  b,
    input  de2u_pkg::tag_t  tag_in,
    output logic            out_vld,
    output de2u_pkg::dbl_t  res,
    output de2u_pkg::tag_t  tag_out
);

    typedef struct packed {
        logic sign;
        logic zsign;
        logic sub;
        logic inf;
        logic nan;
    } afl_t;

    de2u_pkg::dbl_t big;
    de2u_pkg::dbl_t sml;
    logic [10:0]    eb_eff;
    logic [10:0]    es_eff;
    afl_t           fl_next;
    logic [5:0]     amt;
    logic [55:0]    ext;
    logic [55:0]    shifted;
    logic [55:0]    al_next;
    logic [56:0]    sum_next;
    logic [5:0]     lz_next;
    logic [5:0]     lzm1;
    logic [10:0]    emax;
    logic [5:0]     sh;
    logic [55:0]    n_next;
    logic [11:0]    ef_next;
    logic [10:0]    ef_fld;
    logic           rnd;
    logic [62:0]    rounded;
    de2u_pkg::dbl_t res_next;

    logic [5:0]     vld_reg;
    de2u_pkg::tag_t tag_reg [0:5];
    afl_t           fl_reg [0:4];
    logic [10:0]    ebig_reg [0:3];
    logic [52:0]    mbig_reg;
    logic [52:0]    msml_reg;
    logic [10:0]    d_reg;
    logic [55:0]    big_reg;
    logic [55:0]    al_reg;
    logic [56:0]    sum_reg [0:1];
    logic [5:0]     lz_reg;
    logic           zero_reg [0:1];
    logic [55:0]    n_reg;
    logic [11:0]    ef_reg;
    de2u_pkg::dbl_t res_reg;

    // order operands by magnitude
    always_comb
    begin
        big    = (a[62:0] >= b[62:0]) ? a : b;
        sml    = (a[62:0] >= b[62:0]) ? b : a;
        eb_eff = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        es_eff = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
        fl_next.sign  = big[63];
        fl_next.zsign = a[63] & b[63];
        fl_next.sub   = a[63] ^ b[63];
        fl_next.inf   = (a[62:52] == 11'h7FF) || (b[62:52] == 11'h7FF);
        fl_next.nan   = (a[62:52] == 11'h7FF && a[51:0] != 52'd0) ||
                        (b[62:52] == 11'h7FF && b[51:0] != 52'd0) ||
                        (a[62:52] == 11'h7FF && b[62:52] == 11'h7FF &&
                         (a[63] ^ b[63]));
    end

    // align the smaller operand, keep guard, round and sticky
    always_comb
    begin
        amt     = (d_reg > 11'd63) ? 6'd63 : d_reg[5:0];
        ext     = {msml_reg, 3'b000};
        shifted = ext >> amt;
        al_next = {shifted[55:1], shifted[0] | (|(ext & ~({56{1'b1}} << amt)))};
    end

    assign sum_next = fl_reg[1].sub ? ({1'b0, big_reg} - {1'b0, al_reg}) :
                                      ({1'b0, big_reg} + {1'b0, al_reg});

    always_comb
    begin
        lz_next = 6'd57;
        for (int i = 0; i < 57; i++)
        begin
            if (sum_reg[0][i])
                lz_next = 6'(56 - i);
        end
    end

    // normalize, limited by the subnormal boundary
    always_comb
    begin
        lzm1 = lz_reg - 6'd1;
        emax = ebig_reg[3] - 11'd1;
        if (sum_reg[1][56])
        begin
            sh      = 6'd0;
            n_next  = {sum_reg[1][56:2], sum_reg[1][1] | sum_reg[1][0]};
            ef_next = {1'b0, ebig_reg[3]} + 12'd1;
        end
        else
        begin
            sh      = ({5'd0, lzm1} < emax) ? lzm1 : emax[5:0];
            n_next  = sum_reg[1][55:0] << sh;
            ef_next = {1'b0, ebig_reg[3]} - {6'd0, sh};
        end
    end

    // round to nearest even
    always_comb
    begin
        ef_fld  = n_reg[55] ? ef_reg[10:0] : 11'd0;
        rnd     = n_reg[2] & (n_reg[1] | n_reg[0] | n_reg[3]);
        rounded = {ef_fld, n_reg[54:3]} + 63'(rnd);
        if (fl_reg[4].nan)
            res_next = de2u_pkg::QNAN;
        else if (fl_reg[4].inf)
            res_next = {fl_reg[4].sign, de2u_pkg::POS_INF[62:0]};
        else if (zero_reg[1])
            res_next = {fl_reg[4].zsign, 63'd0};
        else if (n_reg[55] && ef_reg >= 12'd2047)
            res_next = {fl_reg[4].sign, de2u_pkg::POS_INF[62:0]};
        else
            res_next = {fl_reg[4].sign, rounded};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mbig_reg    <= {big[62:52] != 11'd0, big[51:0]};
            msml_reg    <= {sml[62:52] != 11'd0, sml[51:0]};
            d_reg       <= eb_eff - es_eff;
            ebig_reg[0] <= eb_eff;
            big_reg     <= {mbig_reg, 3'b000};
            al_reg      <= al_next;
            sum_reg[0]  <= sum_next;
            sum_reg[1]  <= sum_reg[0];
            lz_reg      <= lz_next;
            zero_reg[0] <= (sum_reg[0] == 57'd0);
            zero_reg[1] <= zero_reg[0];
            n_reg       <= n_next;
            ef_reg      <= ef_next;
            res_reg     <= res_next;
            fl_reg[0]   <= fl_next;
            tag_reg[0]  <= tag_in;
            for (int i = 1; i < 4; i++)
                ebig_reg[i] <= ebig_reg[i-1];
            for (int i = 1; i < 5; i++)
                fl_reg[i] <= fl_reg[i-1];
            for (int i = 1; i < 6; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    assign out_vld = vld_reg[5];
    assign res     = res_reg;
    assign tag_out = tag_reg[5];

endmodule

### rtl/double_exp2_unit_core.sv
`timescale 1ns / 1ps
// double_exp2_unit_core: 2^x for one IEEE-754 double per word.
//
// operand carries x_bits, result carries result_bits; both are valid/ready
// channels and a word moves at a clock edge with valid and ready high.
// NaN passes through unchanged, x >= 1024 gives +inf, x <= -1075 gives +0.
// Otherwise x splits into integer k and fraction f, 2^f comes from a
// degree-7 Horner chain of separately rounded double multiplies and adds,
// and the value is scaled by 2^k (with a 2^-1022 pre-scale for small k).
//
// From operand accept to result valid, a word passes one reduction
// stage, nine adders of six stages, nine multipliers of five stages, and
// the output register. One word per cycle is taken unless the receiver stalls.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a word in the output register, the whole
// pipeline holds in place and operand.ready drops; nothing is lost.

module double_exp2_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    de2u_in_if.sink     operand,
    de2u_out_if.source  result
);

    logic            en;
    logic            out_vld_reg;
    de2u_pkg::dbl_t  out_res_reg;

    logic            rr_vld;
    de2u_pkg::dbl_t  rr_a;
    de2u_pkg::dbl_t  rr_b;
    de2u_pkg::tag_t  rr_tag;

    logic            a0_vld;
    de2u_pkg::dbl_t  a0_res;
    de2u_pkg::tag_t  a0_tag;
    de2u_pkg::tag_t  a1_tag_in;
    logic            f_neg;

    logic            a1_vld;
    de2u_pkg::dbl_t  a1_res;
    de2u_pkg::tag_t  a1_tag;
    de2u_pkg::dbl_t  f_red;

    logic            hv [0:7];
    de2u_pkg::dbl_t  hp [0:7];
    de2u_pkg::tag_t  ht [0:7];
    logic            mv [0:6];
    de2u_pkg::dbl_t  mt [0:6];
    de2u_pkg::tag_t  mtag [0:6];

    logic            pre;
    de2u_pkg::tag_t  ps_tag_in;
    logic            ps_vld;
    de2u_pkg::dbl_t  ps_res;
    de2u_pkg::tag_t  ps_tag;
    logic [10:0]     sc_exp;

    logic            fin_vld;
    de2u_pkg::dbl_t  fin_res;
    de2u_pkg::tag_t  fin_tag;
    de2u_pkg::dbl_t  out_next;

    assign en            = !out_vld_reg || result.ready;
    assign operand.ready = en;

    de2u_rred u_rred (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (operand.valid),
        .x       (operand.x_bits),
        .out_vld (rr_vld),
        .a       (rr_a),
        .b       (rr_b),
        .tag_out (rr_tag)
    );

    // f = x - trunc(x)
    de2u_fadd u_add_frac (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (rr_vld),
        .a       (rr_a),
        .b       (rr_b),
        .tag_in  (rr_tag),
        .out_vld (a0_vld),
        .res     (a0_res),
        .tag_out (a0_tag)
    );

    always_comb
    begin
        f_neg           = a0_res[63] && (a0_res[62:0] != 63'd0);
        a1_tag_in       = a0_tag;
        a1_tag_in.f     = a0_res;
        a1_tag_in.f_neg = f_neg;
        a1_tag_in.k     = f_neg ? (a0_tag.k - 12'sd1) : a0_tag.k;
    end

    // move a negative fraction into [0,1]
    de2u_fadd u_add_wrap (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (a0_vld),
        .a       (a0_res),
        .b       (de2u_pkg::ONE),
        .tag_in  (a1_tag_in),
        .out_vld (a1_vld),
        .res     (a1_res),
        .tag_out (a1_tag)
    );

    assign f_red = a1_tag.f_neg ? a1_res : a1_tag.f;

    always_comb
    begin
        hv[0]   = a1_vld;
        hp[0]   = de2u_pkg::COEF[de2u_pkg::NCOEF-1];
        ht[0]   = a1_tag;
        ht[0].f = f_red;
    end

    for (genvar j = 0; j < de2u_pkg::NCOEF; j++)
    begin : g_horner
        localparam de2u_pkg::dbl_t CADD =
            (j == de2u_pkg::NCOEF - 1) ? de2u_pkg::ONE
                                       : de2u_pkg::COEF[de2u_pkg::NCOEF-2-j];

        de2u_fmul u_mul (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_vld  (hv[j]),
            .a       (ht[j].f),
            .b       (hp[j]),
            .tag_in  (ht[j]),
            .out_vld (mv[j]),
            .res     (mt[j]),
            .tag_out (mtag[j])
        );

        de2u_fadd u_add (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_vld  (mv[j]),
            .a       (CADD),
            .b       (mt[j]),
            .tag_in  (mtag[j]),
            .out_vld (hv[j+1]),
            .res     (hp[j+1]),
            .tag_out (ht[j+1])
        );
    end

    always_comb
    begin
        pre         = ht[7].k < -de2u_pkg::K_MIN_NORM;
        ps_tag_in   = ht[7];
        ps_tag_in.k = pre ? (ht[7].k + de2u_pkg::K_MIN_NORM) : ht[7].k;
    end

    de2u_fmul u_mul_pre (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (hv[7]),
        .a       (hp[7]),
        .b       (pre ? de2u_pkg::MIN_NORM : de2u_pkg::ONE),
        .tag_in  (ps_tag_in),
        .out_vld (ps_vld),
        .res     (ps_res),
        .tag_out (ps_tag)
    );

    assign sc_exp = 11'(ps_tag.k + de2u_pkg::K_BIAS);

    de2u_fmul u_mul_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (ps_vld),
        .a       (ps_res),
        .b       ({1'b0, sc_exp, 52'd0}),
        .tag_in  (ps_tag),
        .out_vld (fin_vld),
        .res     (fin_res),
        .tag_out (fin_tag)
    );

    always_comb
    begin
        case (fin_tag.spec)
            de2u_pkg::SPEC_NAN:  out_next = fin_tag.x_raw;
            de2u_pkg::SPEC_INF:  out_next = de2u_pkg::POS_INF;
            de2u_pkg::SPEC_ZERO: out_next = 64'd0;
            default:             out_next = fin_res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= fin_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_res_reg <= out_next;
    end

    assign result.valid       = out_vld_reg;
    assign result.result_bits = out_res_reg;

    // only a passed-through NaN may carry a sign
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.result_bits[63] |->
            result.result_bits[62:52] == 11'h7FF && result.result_bits[51:0] != 52'd0)
        else $error("negative non-NaN result");

    // reduced fraction lies in [0,1]
    assert property (@(posedge clk) disable iff (!rst_n)
        a1_vld && a1_tag.spec == de2u_pkg::SPEC_NONE |->
            (!f_red[63] || f_red[62:0] == 63'd0) && f_red[62:0] <= de2u_pkg::ONE[62:0])
        else $error("fraction out of range");

    // a stall freezes the end of the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(fin_vld) && $stable(fin_res))
        else $error("pipeline moved during stall");

endmodule

### test/tb_double_exp2_unit_core.sv
`timescale 1ns / 1ps

module tb_double_exp2_unit_core;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;

    localparam real POLY [0:6] = '{
        0.693147180559945286,
        0.240226506959100712,
        0.055504108664821609,
        0.009618129107628477,
        0.001333355814642844,
        0.000154035303933816,
        0.000015252733804456
    };

    logic clk;
    logic rst_n;

    de2u_in_if  in_ch ();
    de2u_out_if out_ch ();

    double_exp2_unit_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (in_ch),
        .result  (out_ch)
    );

    de2u_pkg::dbl_t pow2_q[$];
    int   mismatches;
    int   idle_cycles;
    bit   timed_out;
    bit   rx_stall_mode;
    int   hold_req;
    int   hold_cnt;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic de2u_pkg::dbl_t pow2_of(de2u_pkg::dbl_t xb);
        real    x;
        real    f;
        real    p;
        real    t;
        integer k;
        logic [10:0] e;
        if (xb[62:52] == 11'h7FF && xb[51:0] != 52'd0)
            return xb;
        x = $bitstoreal(xb);
        if (x >= 1024.0)
            return de2u_pkg::POS_INF;
        if (x <= -1075.0)
            return 64'd0;
        k = $rtoi(x);
        t = k;
        f = x - t;
        if (f < 0.0)
        begin
            f = f + 1.0;
            k = k - 1;
        end
        p = POLY[6];
        for (int i = 5; i >= 0; i--)
        begin
            t = f * p;
            p = POLY[i] + t;
        end
        t = f * p;
        p = 1.0 + t;
        if (k < -1022)
        begin
            p = p * $bitstoreal(de2u_pkg::MIN_NORM);
            k = k + 1022;
        end
        e = 11'(k + 1023);
        p = p * $bitstoreal({1'b0, e, 52'd0});
        return $realtobits(p);
    endfunction

    // receiver: random stall pattern or always ready, long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= 0;
        end
        else if (hold_req > 0)
        begin
            hold_cnt     <= hold_req;
            hold_req     = 0;
            out_ch.ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt     <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end
        else if (rx_stall_mode)
            out_ch.ready <= ($urandom_range(0, 4) > 1);
        else
            out_ch.ready <= 1'b1;
    end

    // predict on accept, check on result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                pow2_q.push_back(pow2_of(in_ch.x_bits));
            if (out_ch.valid && out_ch.ready)
            begin
                if (pow2_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", out_ch.result_bits);
                end
                else
                begin
                    de2u_pkg::dbl_t want;
                    want = pow2_q.pop_front();
                    if (want !== out_ch.result_bits)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result_bits: expected %h actual %h",
                                     want, out_ch.result_bits);
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end
    end

    task automatic send_word(input de2u_pkg::dbl_t v);
        in_ch.valid  <= 1'b1;
        in_ch.x_bits <= v;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic gap_maybe(inout int burst);
        if (burst > 0)
            burst--;
        else
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst = $urandom_range(0, 20);
        end
    endtask

    function automatic de2u_pkg::dbl_t in_range_x();
        logic [10:0] e;
        e = 11'($urandom_range(1000, 1033));
        return {$urandom_range(0, 1) == 1, e, 52'({$urandom, $urandom})};
    endfunction

    task automatic test_specials();
        de2u_pkg::dbl_t vals[$];
        int burst;
        vals = '{64'h0000000000000000, 64'h8000000000000000, de2u_pkg::ONE,
                 64'hBFF0000000000000,
                 64'h3FE0000000000000, 64'hBFE0000000000000,
                 $realtobits(1023.999), $realtobits(1024.0), $realtobits(1023.0),
                 $realtobits(-1075.0), $realtobits(-1074.5), $realtobits(-1022.5),
                 $realtobits(-1023.0), $realtobits(-1022.0), de2u_pkg::POS_INF,
                 64'hFFF0000000000000, de2u_pkg::QNAN, 64'h7FF0000000000001,
                 64'hFFFFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 64'h0000000000000001,
                 $realtobits(1.0e-300), $realtobits(-1.0e-20), $realtobits(-0.25)};
        burst = 5;
        foreach (vals[i])
        begin
            send_word(vals[i]);
            gap_maybe(burst);
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic test_random(input int count);
        int burst;
        de2u_pkg::dbl_t v;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                v = {$urandom, $urandom};
            else
                v = in_range_x();
            if (i % 300 == 150)
                rx_stall_mode = ~rx_stall_mode;
            send_word(v);
            gap_maybe(burst);
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req = 300;
        for (int i = 0; i < 200; i++)
            send_word(in_range_x());
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        mismatches    = 0;
        idle_cycles   = 0;
        timed_out     = 1'b0;
        rx_stall_mode = 1'b1;
        hold_req      = 0;
        in_ch.valid   = 1'b0;
        in_ch.x_bits  = 64'd0;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_specials();
        test_random(900);
        test_backpressure();
        test_random(100);
        while (pow2_q.size() != 0 && !timed_out)
            @(posedge clk);
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && !timed_out && pow2_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (timed_out)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

### double_exp2_unit_core.f
rtl/de2u_pkg.sv
rtl/de2u_in_if.sv
rtl/de2u_out_if.sv
rtl/de2u_rred.sv
rtl/de2u_fmul.sv
rtl/de2u_fadd.sv
rtl/double_exp2_unit_core.sv
test/tb_double_exp2_unit_core.sv
